// File: src/pra_pkg.sv
// Shared types, codes and saturating arithmetic for the page run allocator.
package pra_pkg;

    localparam int          CNT_W   = 17;
    localparam int          PAGE_W  = 16;
    localparam logic [16:0] CNT_MAX = 17'h10000;
    localparam logic [16:0] NULL_RUN = 17'h10000;
    localparam int          FRAME_SHIFT = 12;

    typedef enum logic [2:0] {
        ACT_ADD_RUN   = 3'd0,
        ACT_RESERVE   = 3'd1,
        ACT_UNRESERVE = 3'd2,
        ACT_ALLOC     = 3'd3,
        ACT_FREE      = 3'd4,
        ACT_ALLOC_RSV = 3'd5,
        ACT_FREE_RET  = 3'd6,
        ACT_NOP       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_AVAIL = 2'd1,
        STS_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] next;
    } t_run_entry;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// File: src/pra_run_mem.sv
// Run table memory: length and next link per run head, registered read.
module pra_run_mem
    import pra_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_run_entry    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_run_entry    o_rdata
);

    t_run_entry r_mem [DEPTH];
    t_run_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/page_run_free_list_allocator_core.sv
// Page run allocator top: LIFO free run list held in one run memory.
// Response: add, reserve, unreserve, free and failed allocations give their word in
// the cycle after acceptance; a successful allocate reads the head run entry, then
// updates it in S_TAKE and registers its word there. Throughput: one word per cycle
// while the output is not stalled; an allocate in S_TAKE holds off new requests.
// Reset: list empty, all counters zero; run memory contents are not cleared.
module page_run_free_list_allocator_core
    import pra_pkg::*;
#(
    parameter int PAGE_COUNT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_page,
    input  logic [16:0] i_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_page,
    output logic [16:0] o_total_pages,
    output logic [16:0] o_available_pages,
    output logic [16:0] o_free_pages_now
);

    localparam int PAGE_SPACE = (PAGE_COUNT < 65536) ? PAGE_COUNT : 65536;
    localparam int AW         = $clog2(PAGE_SPACE);
    localparam logic [CNT_W-1:0] SPACE_W = CNT_W'(PAGE_SPACE);

    typedef enum logic {
        S_IDLE,
        S_TAKE
    } t_state;

    t_state              r_state, n_state;
    logic                r_o_valid, n_o_valid;
    t_status             r_status, n_status;
    logic [PAGE_W-1:0]   r_granted, n_granted;
    logic [CNT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_avail, n_avail;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_o_total, r_o_avail, r_o_free;
    logic                r_rsv, n_rsv;

    logic                w_acc;
    logic                w_load;
    logic                w_page_ok;
    logic                w_have_head;
    logic [CNT_W-1:0]    w_room;
    logic [CNT_W-1:0]    w_n;
    logic [CNT_W-1:0]    w_len;
    logic [CNT_W-1:0]    w_new_len;
    logic [CNT_W-1:0]    w_sum;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    t_run_entry          w_wdata;
    logic                w_re;
    t_run_entry          w_rdata;

    pra_run_mem #(
        .DEPTH (PAGE_SPACE),
        .AW    (AW)
    ) u_run_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_ready     = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign w_acc       = i_valid && o_ready;
    assign w_page_ok   = {1'b0, i_page} < SPACE_W;
    assign w_have_head = r_head < SPACE_W;
    assign w_room      = SPACE_W - {1'b0, i_page};
    assign w_n         = (i_count > w_room) ? w_room : i_count;
    assign w_len       = (w_rdata.len == '0) ? CNT_W'(1) : w_rdata.len;
    assign w_new_len   = w_len - CNT_W'(1);
    assign w_sum       = r_head + w_new_len;

    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid;
        n_status  = r_status;
        n_granted = r_granted;
        n_head    = r_head;
        n_total   = r_total;
        n_avail   = r_avail;
        n_free    = r_free;
        n_rsv     = r_rsv;
        w_load    = 1'b0;
        w_we      = 1'b0;
        w_waddr   = i_page[AW-1:0];
        w_wdata   = '{len: CNT_W'(1), next: r_head};
        w_re      = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_load    = 1'b1;
                    n_status  = STS_OK;
                    n_granted = '0;
                    unique case (t_action'(i_action))
                        ACT_ADD_RUN: begin
                            if (w_page_ok && (w_n != '0)) begin
                                w_we    = 1'b1;
                                w_wdata = '{len: w_n, next: r_head};
                                n_head  = {1'b0, i_page};
                                n_total = sat_add(r_total, w_n);
                                n_avail = sat_add(r_avail, w_n);
                                n_free  = sat_add(r_free, w_n);
                            end
                        end
                        ACT_RESERVE: begin
                            if (i_count <= r_avail) begin
                                n_avail = r_avail - i_count;
                            end else begin
                                n_status = STS_NO_AVAIL;
                            end
                        end
                        ACT_UNRESERVE: begin
                            n_avail = sat_add(r_avail, i_count);
                        end
                        ACT_ALLOC: begin
                            if (!w_have_head) begin
                                n_status = STS_EMPTY;
                            end else begin
                                w_load  = 1'b0;
                                w_re    = 1'b1;
                                n_rsv   = 1'b0;
                                n_state = S_TAKE;
                            end
                        end
                        ACT_ALLOC_RSV: begin
                            if (r_avail == '0) begin
                                n_status = STS_NO_AVAIL;
                            end else if (!w_have_head) begin
                                n_status = STS_EMPTY;
                            end else begin
                                w_load  = 1'b0;
                                w_re    = 1'b1;
                                n_rsv   = 1'b1;
                                n_state = S_TAKE;
                            end
                        end
                        ACT_FREE, ACT_FREE_RET: begin
                            if (w_page_ok) begin
                                w_we   = 1'b1;
                                n_head = {1'b0, i_page};
                                n_free = sat_add(r_free, CNT_W'(1));
                                if (t_action'(i_action) == ACT_FREE_RET) begin
                                    n_avail = sat_add(r_avail, CNT_W'(1));
                                end
                            end
                        end
                        ACT_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TAKE: begin
                w_we      = 1'b1;
                w_waddr   = r_head[AW-1:0];
                w_wdata   = '{len: w_new_len, next: w_rdata.next};
                if (w_new_len == '0) begin
                    n_head = w_rdata.next;
                end
                n_free    = (r_free != '0) ? (r_free - CNT_W'(1)) : '0;
                if (r_rsv) begin
                    n_avail = r_avail - CNT_W'(1);
                end
                n_status  = STS_OK;
                n_granted = w_sum[PAGE_W-1:0];
                w_load    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_head    <= NULL_RUN;
            r_total   <= '0;
            r_avail   <= '0;
            r_free    <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_head    <= n_head;
            r_total   <= n_total;
            r_avail   <= n_avail;
            r_free    <= n_free;
        end
        r_rsv     <= n_rsv;
        r_status  <= n_status;
        r_granted <= n_granted;
        if (w_load) begin
            r_o_total <= n_total;
            r_o_avail <= n_avail;
            r_o_free  <= n_free;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_status;
    assign o_granted_page    = r_granted;
    assign o_total_pages     = r_o_total;
    assign o_available_pages = r_o_avail;
    assign o_free_pages_now  = r_o_free;

endmodule
